FILE: src/fswp_pkg.sv
// Shared types, constants and the arctangent table for the four-step wrapped phase block.
// No dependencies; every other file in src except fswp_checker imports this package.
`timescale 1ns / 1ps

package fswp_pkg;

    // Default widths of the sample and phase fields.
    localparam int SAMPLE_BITS_DEF = 8;
    localparam int PHASE_BITS_DEF  = 16;

    // Rotation datapath: 31 iterations, inputs scaled by 2^30, 32-bit turn accumulator.
    localparam int CORDIC_STEPS = 31;
    localparam int PRESCALE     = 30;
    localparam int ANGLE_W      = 32;
    // Extra bits above the scaled input for CORDIC gain and the first add.
    localparam int GUARD_BITS   = 3;

    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

    // Quadrant codes for the exact axis results, in quarter turns.
    localparam logic [1:0] QUAD_POS_X = 2'd0;
    localparam logic [1:0] QUAD_POS_Y = 2'd1;
    localparam logic [1:0] QUAD_NEG_X = 2'd2;
    localparam logic [1:0] QUAD_NEG_Y = 2'd3;

    // Per-item control that rides along with the rotation datapath.
    typedef struct packed {
        logic       special;   // result is an exact axis value, not the rotation angle
        logic       nomod;     // both differences are zero
        logic [1:0] quad;      // axis result in quarter turns
    } ctrl_t;

    // atan(2^-idx) in units of 2^-32 turn, rounded to nearest.
    function automatic logic [ANGLE_W-1:0] angle_step(input int idx);
        logic [ANGLE_W-1:0] a;
        case (idx)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            24: a = 32'd41;
            25: a = 32'd20;
            26: a = 32'd10;
            27: a = 32'd5;
            28: a = 32'd3;
            29: a = 32'd1;
            30: a = 32'd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: src/fswp_prep.sv
// Input stage: sample differences, axis classification, half-turn fold and prescale.
// Depends on fswp_pkg.
`timescale 1ns / 1ps

module fswp_prep
    import fswp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int XW          = SAMPLE_BITS_DEF + PRESCALE + GUARD_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_BITS-1:0]  sample_a,
    input  logic [SAMPLE_BITS-1:0]  sample_b,
    input  logic [SAMPLE_BITS-1:0]  sample_c,
    input  logic [SAMPLE_BITS-1:0]  sample_d,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [XW-1:0]    x_out,
    output logic signed [XW-1:0]    y_out,
    output logic [ANGLE_W-1:0]      z_out,
    output ctrl_t                   ctrl_out
);

    localparam int DW = SAMPLE_BITS + 1;

    logic signed [DW-1:0]   x_diff;
    logic signed [DW-1:0]   y_diff;
    logic signed [DW-1:0]   x_fold;
    logic signed [DW-1:0]   y_fold;
    logic                   x_zero;
    logic                   y_zero;
    logic                   x_neg;
    logic                   y_neg;
    ctrl_t                  ctrl_next;
    logic                   valid_reg;
    logic signed [XW-1:0]   x_reg;
    logic signed [XW-1:0]   y_reg;
    logic [ANGLE_W-1:0]     z_reg;
    ctrl_t                  ctrl_reg;

    // Differences X = a - c and Y = d - b.
    assign x_diff = signed'({1'b0, sample_a}) - signed'({1'b0, sample_c});
    assign y_diff = signed'({1'b0, sample_d}) - signed'({1'b0, sample_b});
    assign x_zero = (x_diff == '0);
    assign y_zero = (y_diff == '0);
    assign x_neg  = x_diff[DW-1];
    assign y_neg  = y_diff[DW-1];

    // Axis cases and the no-modulation case bypass the rotation result.
    always_comb
    begin
        ctrl_next.special = x_zero || y_zero;
        ctrl_next.nomod   = x_zero && y_zero;
        if (y_zero && !x_neg)
        begin
            ctrl_next.quad = QUAD_POS_X;
        end
        else if (y_zero)
        begin
            ctrl_next.quad = QUAD_NEG_X;
        end
        else if (!y_neg)
        begin
            ctrl_next.quad = QUAD_POS_Y;
        end
        else
        begin
            ctrl_next.quad = QUAD_NEG_Y;
        end
    end

    // A vector in the left half plane is turned by half a turn first.
    assign x_fold = x_neg ? -x_diff : x_diff;
    assign y_fold = x_neg ? -y_diff : y_diff;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg    <= signed'({{(XW-DW-PRESCALE){x_fold[DW-1]}}, x_fold,
                                 {PRESCALE{1'b0}}});
            y_reg    <= signed'({{(XW-DW-PRESCALE){y_fold[DW-1]}}, y_fold,
                                 {PRESCALE{1'b0}}});
            z_reg    <= x_neg ? HALF_TURN : '0;
            ctrl_reg <= ctrl_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign ctrl_out  = ctrl_reg;

endmodule

FILE: src/fswp_cordic_stage.sv
// One vectoring CORDIC iteration as a registered pipeline stage with its own valid bit.
// Depends on fswp_pkg for the angle table and the control struct.
`timescale 1ns / 1ps

module fswp_cordic_stage
    import fswp_pkg::*;
#(
    parameter int IDX = 0,
    parameter int XW  = SAMPLE_BITS_DEF + PRESCALE + GUARD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [XW-1:0]  x_in,
    input  logic signed [XW-1:0]  y_in,
    input  logic [ANGLE_W-1:0]    z_in,
    input  ctrl_t                 ctrl_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [XW-1:0]  x_out,
    output logic signed [XW-1:0]  y_out,
    output logic [ANGLE_W-1:0]    z_out,
    output ctrl_t                 ctrl_out
);

    localparam logic [ANGLE_W-1:0] STEP_ANGLE = angle_step(IDX);

    logic signed [XW-1:0]  dx;
    logic signed [XW-1:0]  dy;
    logic                  y_pos;
    logic                  valid_reg;
    logic signed [XW-1:0]  x_reg;
    logic signed [XW-1:0]  y_reg;
    logic [ANGLE_W-1:0]    z_reg;
    ctrl_t                 ctrl_reg;

    // Arithmetic shifts round toward minus infinity.
    assign dx    = y_in >>> IDX;
    assign dy    = x_in >>> IDX;
    assign y_pos = !y_in[XW-1] && (y_in != '0);

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Turn clockwise while y is above the axis, counterclockwise otherwise.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            if (y_pos)
            begin
                x_reg <= x_in + dx;
                y_reg <= y_in - dy;
                z_reg <= z_in + STEP_ANGLE;
            end
            else
            begin
                x_reg <= x_in - dx;
                y_reg <= y_in + dy;
                z_reg <= z_in - STEP_ANGLE;
            end
            ctrl_reg <= ctrl_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign ctrl_out  = ctrl_reg;

endmodule

FILE: src/fswp_out.sv
// Output stage: rounds the turn accumulator to the phase width or picks the exact axis value.
// Depends on fswp_pkg.
`timescale 1ns / 1ps

module fswp_out
    import fswp_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ANGLE_W-1:0]     z_in,
    input  ctrl_t                  ctrl_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PHASE_BITS-1:0]  wrapped_phase,
    output logic                   no_modulation
);

    logic [ANGLE_W:0]       z_round;
    logic [PHASE_BITS-1:0]  phase_next;
    logic                   valid_reg;
    logic [PHASE_BITS-1:0]  phase_reg;
    logic                   nomod_reg;

    // Round half up; a carry into a full turn wraps to zero.
    assign z_round = {1'b0, z_in} + ((ANGLE_W+1)'(1) << (ANGLE_W - 1 - PHASE_BITS));

    always_comb
    begin
        if (ctrl_in.special)
        begin
            phase_next = {ctrl_in.quad, {(PHASE_BITS-2){1'b0}}};
        end
        else
        begin
            phase_next = z_round[ANGLE_W-1 -: PHASE_BITS];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            phase_reg <= phase_next;
            nomod_reg <= ctrl_in.nomod;
        end
    end

    assign out_valid     = valid_reg;
    assign wrapped_phase = phase_reg;
    assign no_modulation = nomod_reg;

endmodule

FILE: src/four_step_wrapped_phase.sv
// Four-step phase-shift wrapped phase: one pixel item per clock.
// The pipeline is one input stage, 31 CORDIC iteration stages and one output stage.
// Throughput is one item per cycle; each stage has its own valid bit and holds when
// the stage after it is full and stalled, so bubbles are filled during a stall.
// rst_n clears all valid bits asynchronously; data registers are not reset.
// Depends on fswp_pkg, fswp_prep, fswp_cordic_stage and fswp_out.
`timescale 1ns / 1ps

module four_step_wrapped_phase
    import fswp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = PHASE_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // sample_a, sample_b, sample_c, sample_d from bit 0 up, zero padding on top
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // wrapped_phase from bit 0 up, zero padding on top
    output logic [((PHASE_BITS+7)/8)*8-1:0]      m_tdata,
    // no_modulation
    output logic                                 m_tuser
);

    localparam int XW          = SAMPLE_BITS + PRESCALE + GUARD_BITS;
    localparam int OUT_TDATA_W = ((PHASE_BITS + 7) / 8) * 8;

    logic signed [XW-1:0]   x_s     [0:CORDIC_STEPS];
    logic signed [XW-1:0]   y_s     [0:CORDIC_STEPS];
    logic [ANGLE_W-1:0]     z_s     [0:CORDIC_STEPS];
    ctrl_t                  ctrl_s  [0:CORDIC_STEPS];
    logic                   valid_s [0:CORDIC_STEPS];
    logic                   ready_s [0:CORDIC_STEPS];
    logic [PHASE_BITS-1:0]  wrapped_phase;

    // Differences, classification and prescale.
    fswp_prep #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .XW          (XW)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .sample_a  (s_tdata[0*SAMPLE_BITS +: SAMPLE_BITS]),
        .sample_b  (s_tdata[1*SAMPLE_BITS +: SAMPLE_BITS]),
        .sample_c  (s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS]),
        .sample_d  (s_tdata[3*SAMPLE_BITS +: SAMPLE_BITS]),
        .out_valid (valid_s[0]),
        .out_ready (ready_s[0]),
        .x_out     (x_s[0]),
        .y_out     (y_s[0]),
        .z_out     (z_s[0]),
        .ctrl_out  (ctrl_s[0])
    );

    // One CORDIC iteration per pipeline stage.
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_stage
        fswp_cordic_stage #(
            .IDX (k),
            .XW  (XW)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_s[k]),
            .in_ready  (ready_s[k]),
            .x_in      (x_s[k]),
            .y_in      (y_s[k]),
            .z_in      (z_s[k]),
            .ctrl_in   (ctrl_s[k]),
            .out_valid (valid_s[k+1]),
            .out_ready (ready_s[k+1]),
            .x_out     (x_s[k+1]),
            .y_out     (y_s[k+1]),
            .z_out     (z_s[k+1]),
            .ctrl_out  (ctrl_s[k+1])
        );
    end

    // Rounding and axis selection into the output register.
    fswp_out #(
        .PHASE_BITS (PHASE_BITS)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (valid_s[CORDIC_STEPS]),
        .in_ready      (ready_s[CORDIC_STEPS]),
        .z_in          (z_s[CORDIC_STEPS]),
        .ctrl_in       (ctrl_s[CORDIC_STEPS]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .wrapped_phase (wrapped_phase),
        .no_modulation (m_tuser)
    );

    assign m_tdata = OUT_TDATA_W'(wrapped_phase);

endmodule

FILE: src/fswp_checker.sv
// Port-level checks for four_step_wrapped_phase, attached to it by the bind below.
// Depends on the top level's port list and its OUT_TDATA_W localparam only.
`timescale 1ns / 1ps

module fswp_checker #(
    parameter int OUT_TDATA_W = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tready,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_TDATA_W-1:0]  m_tdata,
    input  logic                    m_tuser
);

    // Reset empties the pipeline, so no result item is shown in the cycle after a reset cycle.
    property p_reset_empty;
        @(posedge clk) !rst_n |=> !m_tvalid;
    endproperty
    a_reset_empty: assert property (p_reset_empty)
        else $error("result item shown right after reset");

    // A pixel without modulation always reports phase zero.
    property p_nomod_zero;
        @(posedge clk) disable iff (!rst_n)
            (m_tvalid && m_tuser) |-> (m_tdata == '0);
    endproperty
    a_nomod_zero: assert property (p_nomod_zero)
        else $error("no-modulation item with nonzero phase");

    // A stalled result item holds its value.
    property p_stall_hold;
        @(posedge clk) disable iff (!rst_n)
            (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser));
    endproperty
    a_stall_hold: assert property (p_stall_hold)
        else $error("stalled result item changed or dropped");

    // While the output side takes every item, the input side is never held off.
    property p_flow_through;
        @(posedge clk) disable iff (!rst_n)
            (m_tready && $past(m_tready)) |-> s_tready;
    endproperty
    a_flow_through: assert property (p_flow_through)
        else $error("input held off while the output was draining");

endmodule

bind four_step_wrapped_phase fswp_checker #(
    .OUT_TDATA_W (OUT_TDATA_W)
) u_fswp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/sv/four_step_wrapped_phase_test.sv
// Self-checking testbench for four_step_wrapped_phase: walks a directed pixel table and then
// random pixels, with random input gaps and result stalls. Depends on fswp_pkg and the RTL.
`timescale 1ns / 1ps

module four_step_wrapped_phase_test;
    import fswp_pkg::*;

    localparam int SAMPLE_W   = SAMPLE_BITS_DEF;
    localparam int PHASE_W    = PHASE_BITS_DEF;
    localparam int S_DATA_W   = ((4*SAMPLE_W+7)/8)*8;
    localparam int M_DATA_W   = ((PHASE_W+7)/8)*8;
    localparam int N_STEPS    = 31;
    localparam int SCALE_SH   = 30;
    localparam int N_RANDOM   = 1500;
    localparam int DRAIN_CYC  = 40;
    localparam int MAX_SHOWN  = 10;

    localparam logic [PHASE_W-1:0] PH_ZERO    = '0;
    localparam logic [PHASE_W-1:0] PH_QUARTER = PHASE_W'(1) << (PHASE_W-2);
    localparam logic [PHASE_W-1:0] PH_HALF    = PHASE_W'(1) << (PHASE_W-1);
    localparam logic [PHASE_W-1:0] PH_3QUART  = PHASE_W'(3) << (PHASE_W-2);

    // Own copy of atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURN [N_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
        32'd1
    };

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               nomod;
    } pixel_phase_t;

    // One row of the directed table; known marks a result typed in by hand.
    typedef struct {
        sample_t            a;
        sample_t            b;
        sample_t            c;
        sample_t            d;
        bit                 known;
        logic [PHASE_W-1:0] phase;
        logic               nomod;
    } pixel_row_t;

    localparam int N_ROWS = 23;
    pixel_row_t pixel_rows [N_ROWS] = '{
        // No modulation: both differences zero.
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, PH_ZERO,    1'b1},
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, PH_ZERO,    1'b1},
        '{8'd128, 8'd77,  8'd128, 8'd77,  1'b1, PH_ZERO,    1'b1},
        // Positive X axis.
        '{8'd255, 8'd0,   8'd0,   8'd0,   1'b1, PH_ZERO,    1'b0},
        '{8'd1,   8'd9,   8'd0,   8'd9,   1'b1, PH_ZERO,    1'b0},
        // Negative X axis.
        '{8'd0,   8'd200, 8'd255, 8'd200, 1'b1, PH_HALF,    1'b0},
        '{8'd0,   8'd0,   8'd1,   8'd0,   1'b1, PH_HALF,    1'b0},
        // Positive Y axis.
        '{8'd7,   8'd0,   8'd7,   8'd255, 1'b1, PH_QUARTER, 1'b0},
        '{8'd7,   8'd254, 8'd7,   8'd255, 1'b1, PH_QUARTER, 1'b0},
        // Negative Y axis.
        '{8'd0,   8'd255, 8'd0,   8'd0,   1'b1, PH_3QUART,  1'b0},
        '{8'd255, 8'd1,   8'd255, 8'd0,   1'b1, PH_3QUART,  1'b0},
        // Diagonals, near-axis vectors and the wrap just below a full turn.
        '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0, PH_ZERO,    1'b0},
        '{8'd0,   8'd0,   8'd255, 8'd255, 1'b0, PH_ZERO,    1'b0},
        '{8'd0,   8'd255, 8'd255, 8'd0,   1'b0, PH_ZERO,    1'b0},
        '{8'd255, 8'd255, 8'd0,   8'd0,   1'b0, PH_ZERO,    1'b0},
        '{8'd255, 8'd0,   8'd0,   8'd1,   1'b0, PH_ZERO,    1'b0},
        '{8'd255, 8'd1,   8'd0,   8'd0,   1'b0, PH_ZERO,    1'b0},
        '{8'd0,   8'd0,   8'd255, 8'd1,   1'b0, PH_ZERO,    1'b0},
        '{8'd0,   8'd1,   8'd255, 8'd0,   1'b0, PH_ZERO,    1'b0},
        '{8'd1,   8'd0,   8'd0,   8'd255, 1'b0, PH_ZERO,    1'b0},
        '{8'd1,   8'd255, 8'd0,   8'd0,   1'b0, PH_ZERO,    1'b0},
        '{8'd170, 8'd85,  8'd85,  8'd170, 1'b0, PH_ZERO,    1'b0},
        '{8'd85,  8'd170, 8'd170, 8'd85,  1'b0, PH_ZERO,    1'b0}
    };

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // sample_a, sample_b, sample_c, sample_d from bit 0 up
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    // wrapped_phase from bit 0 up
    logic [M_DATA_W-1:0] m_tdata;
    // no_modulation
    logic                m_tuser;

    pixel_phase_t phase_due [$];
    int           mismatches;
    int           stall_left;
    bit           calm;

    four_step_wrapped_phase i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock with a 12 ns period.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Vectoring rotation: angle of (x, y) as a 32-bit turn fraction.
    function automatic logic [31:0] vector_turn(input longint x0, input longint y0);
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [31:0] z;
        x = x0;
        y = y0;
        z = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        x = x * (longint'(1) << SCALE_SH);
        y = y * (longint'(1) << SCALE_SH);
        for (int i = 0; i < N_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURN[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURN[i];
            end
        end
        return z;
    endfunction

    // Wrapped phase of one pixel, with the exact axis and no-modulation cases.
    function automatic pixel_phase_t wrapped_phase_of(input sample_t a, input sample_t b,
                                                      input sample_t c, input sample_t d);
        longint       x;
        longint       y;
        logic [32:0]  rounded;
        pixel_phase_t r;
        x = longint'(a) - longint'(c);
        y = longint'(d) - longint'(b);
        r.nomod = 1'b0;
        if (x == 0 && y == 0)
        begin
            r.phase = PH_ZERO;
            r.nomod = 1'b1;
        end
        else if (y == 0 && x > 0)
        begin
            r.phase = PH_ZERO;
        end
        else if (y == 0)
        begin
            r.phase = PH_HALF;
        end
        else if (x == 0 && y > 0)
        begin
            r.phase = PH_QUARTER;
        end
        else if (x == 0)
        begin
            r.phase = PH_3QUART;
        end
        else
        begin
            // Round half up to PHASE_W bits; a full turn wraps to zero.
            rounded = {1'b0, vector_turn(x, y)} + (33'd1 << (31 - PHASE_W));
            r.phase = rounded[31 -: PHASE_W];
        end
        return r;
    endfunction

    // Gap length: mostly none or short, a few long; none at all in a calm stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one pixel item and wait until the block takes it.
    task automatic send_pixel(input sample_t a, input sample_t b, input sample_t c,
                              input sample_t d, input pixel_phase_t due);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({d, c, b, a});
        do
            @(posedge clk);
        while (!s_tready);
        phase_due = {phase_due, due};
    endtask

    // Random sample that often lands on the extremes.
    function automatic sample_t pick_sample();
        if ($urandom_range(9) == 0)
            return ($urandom_range(1) != 0) ? sample_t'(255 - $urandom_range(1))
                                            : sample_t'($urandom_range(1));
        return sample_t'($urandom);
    endfunction

    // Stimulus: directed table, then random pixels biased toward the axes.
    initial
    begin
        pixel_phase_t due;
        sample_t      a;
        sample_t      b;
        sample_t      c;
        sample_t      d;
        int           kind;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        calm     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (pixel_rows[i])
        begin
            if (pixel_rows[i].known)
            begin
                due.phase = pixel_rows[i].phase;
                due.nomod = pixel_rows[i].nomod;
            end
            else
            begin
                due = wrapped_phase_of(pixel_rows[i].a, pixel_rows[i].b,
                                       pixel_rows[i].c, pixel_rows[i].d);
            end
            send_pixel(pixel_rows[i].a, pixel_rows[i].b, pixel_rows[i].c,
                       pixel_rows[i].d, due);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // Every hundred items, maybe switch to a stretch without idling.
            if (n % 100 == 0)
                calm = ($urandom_range(3) == 0);
            a = pick_sample();
            b = pick_sample();
            c = pick_sample();
            d = pick_sample();
            kind = $urandom_range(99);
            if (kind < 15)
                c = a;
            else if (kind < 30)
                d = b;
            else if (kind < 35)
            begin
                c = a;
                d = b;
            end
            send_pixel(a, b, c, d, wrapped_phase_of(a, b, c, d));
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        // Drain the pipeline and watch for stray results.
        while (phase_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatches == 0 && phase_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Compare one accepted result item with the oldest expected phase.
    task automatic check_phase(input logic [M_DATA_W-1:0] data, input logic flag);
        pixel_phase_t due;
        if (phase_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("Result item with none expected: phase %0d flag %0b", data, flag);
        end
        else
        begin
            due = phase_due.pop_front();
            if (data !== M_DATA_W'(due.phase) || flag !== due.nomod)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("Mismatch: expected phase %0d flag %0b, got phase %0d flag %0b",
                             due.phase, due.nomod, data, flag);
            end
        end
    endtask

    // Result side: check accepted items and stall at random.
    initial
    begin
        m_tready   = 1'b0;
        mismatches = 0;
        stall_left = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_phase(m_tdata, m_tuser);
        if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (!calm && $urandom_range(99) < 25)
        begin
            m_tready   <= 1'b0;
            stall_left = pick_gap();
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
src/fswp_pkg.sv
src/fswp_prep.sv
src/fswp_cordic_stage.sv
src/fswp_out.sv
src/four_step_wrapped_phase.sv
src/fswp_checker.sv
tb/sv/four_step_wrapped_phase_test.sv
